// File: hw/rtl/mac_learning_forwarder_core_assert.svh
// assertion macros for the mac learning forwarder core
`ifndef MAC_LEARNING_FORWARDER_CORE_ASSERT_SVH
`define MAC_LEARNING_FORWARDER_CORE_ASSERT_SVH
`ifndef SYNTH
`define MLF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define MLF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MLF_ASSERT_IMP(lbl, ante, cons, msg)
`define MLF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/mlf_pkg.sv
// shared types and constants of the mac learning forwarder
`timescale 1ns / 1ps
package mlf_pkg;
	localparam int MAC_W     = 48;
	localparam int PORT_W    = 8;
	localparam int GROUP_BIT = 40;

	typedef logic [MAC_W-1:0]  mac_t;
	typedef logic [PORT_W-1:0] port_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;
endpackage

// File: hw/rtl/mlf_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/mac_learning_forwarder_core.sv
// mac learning forwarder: learns source addresses and resolves destination ports
`timescale 1ns / 1ps
`include "mac_learning_forwarder_core_assert.svh"
// Raise start with dst_mac, src_mac and in_port while busy is low; the word is taken at
// that edge. Each frame gives exactly one result, shown on flood and egress_port for a single
// cycle with done high; the result cannot be held off, so sample it when done is high.
// Entries fill the table from the lowest index and never age, and the table is empty after
// reset with no clearing pass. The frame walks every filled entry through the table
// memories, one entry a cycle, then passes through the update state and returns to idle,
// so the time from one accept to the next grows with the fill count. The next frame may
// be started in the cycle its predecessor's result is shown.
module mac_learning_forwarder_core #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mlf_pkg::mac_t dst_mac,
	input  mlf_pkg::mac_t src_mac,
	input  mlf_pkg::port_t in_port,
	output logic          done,
	output logic          flood,
	output mlf_pkg::port_t egress_port
);
	import mlf_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);

	state_t state_q, state_d;

	logic [AW:0]   cnt_q;
	logic [AW:0]   addr_q;
	mac_t          dst_q, src_q;
	port_t         port_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          src_hit_q, dst_hit_q;
	logic [AW-1:0] src_idx_q;
	port_t         dst_port_q;
	logic          done_q, flood_q;
	port_t         egress_port_q;

	logic          accept;
	logic          issue;
	logic          we;
	logic [AW-1:0] waddr;
	mac_t          mac_rd;
	port_t         port_rd;
	logic          src_uni;
	logic          insert;
	logic          learned;
	logic          res_flood;
	port_t         res_port;

	mlf_ram #(.WIDTH(MAC_W), .DEPTH(TABLE_ENTRIES)) u_mac_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (src_q),
		.raddr (addr_q[AW-1:0]),
		.rdata (mac_rd)
	);

	mlf_ram #(.WIDTH(PORT_W), .DEPTH(TABLE_ENTRIES)) u_port_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (port_q),
		.raddr (addr_q[AW-1:0]),
		.rdata (port_rd)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign issue  = (state_q == ST_SCAN) && (addr_q < cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// learn and resolve
	always_comb begin
		src_uni   = !src_q[GROUP_BIT];
		insert    = src_uni && !src_hit_q && (cnt_q < (AW+1)'(TABLE_ENTRIES));
		learned   = src_uni && (src_hit_q || insert);
		we        = 1'b0;
		waddr     = src_hit_q ? src_idx_q : cnt_q[AW-1:0];
		res_flood = 1'b1;
		res_port  = '0;
		unique case (state_q)
			ST_UPDATE: begin
				we = src_uni && (src_hit_q || insert);
				priority if (dst_q[GROUP_BIT]) begin
					res_flood = 1'b1;
				end else if (learned && (dst_q == src_q)) begin
					res_flood = 1'b0;
					res_port  = port_q;
				end else if (dst_hit_q) begin
					res_flood = 1'b0;
					res_port  = dst_port_q;
				end else begin
					res_flood = 1'b1;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			done_q    <= (state_q == ST_UPDATE);
			if ((state_q == ST_UPDATE) && insert) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[AW-1:0];
		if (accept) begin
			dst_q     <= dst_mac;
			src_q     <= src_mac;
			port_q    <= in_port;
			addr_q    <= '0;
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
		end else begin
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (rd_vld_s1 && (mac_rd == src_q)) begin
				src_hit_q <= 1'b1;
				src_idx_q <= rd_idx_s1;
			end
			if (rd_vld_s1 && (mac_rd == dst_q)) begin
				dst_hit_q  <= 1'b1;
				dst_port_q <= port_rd;
			end
		end
		if (state_q == ST_UPDATE) begin
			flood_q       <= res_flood;
			egress_port_q <= res_port;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign flood       = flood_q;
	assign egress_port = egress_port_q;

	`MLF_ASSERT_NXT(a_update_done, state_q == ST_UPDATE, done, "update without result")
	`MLF_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done, "accept did not go busy")
	`MLF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (AW+1)'(TABLE_ENTRIES), "fill count overflow")
	`MLF_ASSERT_IMP(a_flood_port, done && flood, egress_port == '0, "flood with nonzero port")
endmodule

// File: sim/tb_top.sv
// self-checking testbench for the mac learning forwarder core
`timescale 1ns / 1ps
module tb_top;
	import mlf_pkg::*;

	localparam int ENTRIES         = 256;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int RANDOM_FRAMES   = 400;
	localparam int FULL_FRAMES_MIN = 40;
	localparam int PHASE_FRAMES    = 100;
	localparam int IDLE_PCT [3]    = '{0, 57, 21};

	localparam mac_t MAC_ZERO      = 48'h0000_0000_0000;
	localparam mac_t MAC_TOP_UCAST = 48'hFEFF_FFFF_FFFF;
	localparam mac_t MAC_BCAST     = 48'hFFFF_FFFF_FFFF;
	localparam mac_t MAC_MCAST     = 48'h0100_5E00_0001;
	localparam mac_t MAC_LOCAL     = 48'h0200_0000_0001;
	localparam mac_t MAC_MIXED     = 48'h7EDC_BA98_7654;

	typedef struct packed {
		logic  flood;
		port_t port;
	} fwd_result_t;

	class fwd_scoreboard;
		bit          station_valid [ENTRIES];
		mac_t        station_mac   [ENTRIES];
		port_t       station_port  [ENTRIES];
		int          stations;
		int          errors;
		fwd_result_t pending_results [$];

		function new();
			stations = 0;
			errors   = 0;
			foreach (station_valid[i]) station_valid[i] = 1'b0;
		endfunction

		function int find_station(mac_t mac);
			int i;
			for (i = 0; i < ENTRIES; i++) begin
				if (station_valid[i] && station_mac[i] == mac) return i;
			end
			return -1;
		endfunction

		function void learn_source(mac_t mac, port_t port);
			int idx;
			int i;
			idx = find_station(mac);
			i = 0;
			while (idx < 0 && i < ENTRIES) begin
				if (!station_valid[i]) idx = i;
				i++;
			end
			if (idx < 0) return;
			if (!station_valid[idx]) stations++;
			station_valid[idx] = 1'b1;
			station_mac[idx]   = mac;
			station_port[idx]  = port;
		endfunction

		function void note_frame(mac_t dst, mac_t src, port_t port);
			fwd_result_t res;
			int          hit;
			if (!src[GROUP_BIT]) learn_source(src, port);
			res.flood = 1'b1;
			res.port  = '0;
			if (!dst[GROUP_BIT]) begin
				hit = find_station(dst);
				if (hit >= 0) begin
					res.flood = 1'b0;
					res.port  = station_port[hit];
				end
			end
			pending_results.push_back(res);
		endfunction

		function void check_result(logic fl, port_t port);
			fwd_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, flood %0d egress_port %0d", $time, fl, port);
				return;
			end
			want = pending_results.pop_front();
			if (fl !== want.flood) begin
				errors++;
				$display("%0t: flood mismatch, expected %0d actual %0d", $time, want.flood, fl);
			end
			if (port !== want.port) begin
				errors++;
				$display("%0t: egress_port mismatch, expected %0d actual %0d",
					$time, want.port, port);
			end
		endfunction
	endclass

	logic  clk     = 1'b0;
	logic  arst_n  = 1'b0;
	logic  start   = 1'b0;
	mac_t  dst_mac = '0;
	mac_t  src_mac = '0;
	port_t in_port = '0;
	logic  busy;
	logic  done;
	logic  flood;
	port_t egress_port;

	fwd_scoreboard sb;
	mac_t          known_macs [$];
	int            stuck_cycles = 0;

	always #5 clk = ~clk;

	mac_learning_forwarder_core #(
		.TABLE_ENTRIES(ENTRIES)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.dst_mac     (dst_mac),
		.src_mac     (src_mac),
		.in_port     (in_port),
		.done        (done),
		.flood       (flood),
		.egress_port (egress_port)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) sb.check_result(flood, egress_port);
			if (start && busy === 1'b0) sb.note_frame(dst_mac, src_mac, in_port);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1 || (start && busy === 1'b0)) begin
				stuck_cycles <= 0;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
				if (stuck_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog expired", $time);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	function automatic mac_t rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MAC_W-1:0];
	endfunction

	function automatic mac_t rand_ucast();
		mac_t m;
		m = rand_mac();
		m[GROUP_BIT] = 1'b0;
		return m;
	endfunction

	function automatic mac_t rand_group();
		mac_t m;
		m = rand_mac();
		m[GROUP_BIT] = 1'b1;
		return m;
	endfunction

	function automatic mac_t pick_known();
		return known_macs[$urandom_range(0, known_macs.size() - 1)];
	endfunction

	// word stays on the ports until taken; start is left high for the caller
	task automatic send_frame(mac_t dst, mac_t src, port_t port);
		start   = 1'b1;
		dst_mac = dst;
		src_mac = src;
		in_port = port;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		if (!src[GROUP_BIT]) known_macs.push_back(src);
	endtask

	task automatic idle_gap();
		start = 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
	endtask

	initial begin
		int    n;
		int    full_frames;
		int    idle_pct;
		int    roll;
		mac_t  next_src;
		mac_t  next_dst;
		port_t next_port;

		sb = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table, extremes, updates, self lookups, group addresses
		send_frame(MAC_LOCAL, MAC_ZERO, 8'h00);
		send_frame(MAC_ZERO, MAC_TOP_UCAST, 8'hFF);
		send_frame(MAC_TOP_UCAST, MAC_LOCAL, 8'h55);
		send_frame(MAC_BCAST, MAC_LOCAL, 8'hAA);
		send_frame(MAC_LOCAL, MAC_ZERO, 8'h01);
		send_frame(MAC_ZERO, MAC_ZERO, 8'h80);
		send_frame(MAC_MCAST, MAC_MCAST, 8'h03);
		send_frame(MAC_MCAST, MAC_MIXED, 8'h04);
		send_frame(MAC_BCAST, MAC_BCAST, 8'hFF);
		send_frame(48'h0100_0000_0000, MAC_MIXED, 8'h05);
		send_frame(MAC_MIXED, MAC_BCAST, 8'h00);
		send_frame(48'h00FF_FFFF_FFFF, MAC_MIXED, 8'h7F);
		send_frame(MAC_TOP_UCAST, MAC_TOP_UCAST, 8'h00);
		send_frame(MAC_MIXED | 48'h0100_0000_0000, MAC_ZERO, 8'hC3);
		send_frame(MAC_ZERO, MAC_LOCAL, 8'h3C);
		drain_results();

		n = 0;
		full_frames = 0;
		while (n < RANDOM_FRAMES || full_frames < FULL_FRAMES_MIN) begin
			if (n > 0 && n % PHASE_FRAMES == 0) drain_results();
			idle_pct = IDLE_PCT[(n / PHASE_FRAMES) % 3];
			while ($urandom_range(0, 99) < idle_pct) idle_gap();

			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				next_src = rand_ucast();
			end else if (roll < 88) begin
				next_src = pick_known();
			end else if (roll < 96) begin
				next_src = rand_group();
			end else begin
				case ($urandom_range(0, 2))
					0: next_src = MAC_ZERO;
					1: next_src = MAC_TOP_UCAST;
					default: next_src = MAC_BCAST;
				endcase
			end

			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				next_dst = pick_known();
			end else if (roll < 65) begin
				next_dst = next_src;
			end else if (roll < 72) begin
				next_dst = rand_group();
			end else if (roll < 75) begin
				next_dst = MAC_BCAST;
			end else if (roll < 90) begin
				next_dst = rand_mac();
			end else begin
				next_dst = pick_known();
				next_dst[GROUP_BIT] = 1'b1;
			end

			next_port = port_t'($urandom_range(0, 255));
			if (sb.stations == ENTRIES) full_frames++;
			send_frame(next_dst, next_src, next_port);
			n++;
		end

		drain_results();
		repeat (ENTRIES + 20) @(negedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
